// ===== hw/rtl/plfc_pkg.sv =====
// ----------------------------------------------------------------------------
// plfc_pkg
// shared types and constants of the file cache policy unit
// ----------------------------------------------------------------------------
package plfc_pkg;

   localparam int ENTRY_COUNT  = 256;
   localparam int ENTRY_BITS   = $clog2(ENTRY_COUNT);
   localparam int LEVEL_COUNT  = 8;
   localparam int LEVEL_BITS   = $clog2(LEVEL_COUNT);
   localparam int SIZE_BITS    = 40;
   localparam int TOTAL_BITS   = 48;
   localparam int TIME_BITS    = 32;
   localparam int NANO_BITS    = 30;
   localparam int LEN_BITS     = 32;
   localparam int CNT_BITS     = 9;
   localparam int BUDGET_BITS  = 36;
   localparam int TIMEOUT_BITS = 6;
   localparam int MAXFILE_BITS = 20;
   localparam int PLEV_BITS    = 4;
   localparam int CSR_DATA_BITS = 64;
   localparam int CSR_ADDR_BITS = 5;

   localparam logic [BUDGET_BITS-1:0]  BUDGET_RESET  = 36'd134217728;
   localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RESET = 6'd1;
   localparam logic [MAXFILE_BITS-1:0] MAXFILE_RESET = 20'd65536;
   localparam logic [PLEV_BITS-1:0]    PLEV_RESET    = 4'd1;
   localparam logic [TOTAL_BITS-1:0]   TOTAL_MAX     = '1;

   typedef enum logic [1:0] {
      REG_BUDGET  = 2'd0,
      REG_TIMEOUT = 2'd1,
      REG_MAXFILE = 2'd2,
      REG_LEVELS  = 2'd3
   } reg_index_type;

   typedef enum logic [2:0] {
      OP_INSTALL = 3'd0,
      OP_REVAL   = 3'd1,
      OP_READ    = 3'd2,
      OP_INVAL   = 3'd3,
      OP_SETPRI  = 3'd4
   } op_type;

   typedef struct packed {
      logic [BUDGET_BITS-1:0]  budget;
      logic [TIMEOUT_BITS-1:0] timeout;
      logic [MAXFILE_BITS-1:0] maxfile;
      logic [PLEV_BITS-1:0]    levels;
   } cfg_type;

   typedef struct packed {
      logic load_item;
      logic mem_read;
      logic addr_head;
      logic remove;
      logic drop;
      logic write_new;
      logic write_stamp;
      logic write_level;
      logic append;
      logic set_result;
      logic walk_clear;
      logic walk_inc;
      logic cnt_inc;
      logic load_rsp;
   } ctl_cmd_type;

   typedef struct packed {
      logic [2:0] op;
      logic       entry_valid;
      logic       reval_ok;
      logic       read_ok;
      logic       over_budget;
      logic       under_budget;
      logic       walk_nonempty;
      logic       walk_last;
      logic       rsp_free;
   } ctl_sts_type;

endpackage

// ===== hw/rtl/plfc_if.sv =====
// ----------------------------------------------------------------------------
// plfc_req_if / plfc_rsp_if
// request and response channels of the file cache policy unit
// ----------------------------------------------------------------------------
interface plfc_req_if;
   import plfc_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [2:0]             command;
   logic [ENTRY_BITS-1:0]  entry_index;
   logic [SIZE_BITS-1:0]   file_size;
   logic [TIME_BITS-1:0]   mtime_seconds;
   logic [NANO_BITS-1:0]   mtime_nanoseconds;
   logic [TIME_BITS-1:0]   now_seconds;
   logic [SIZE_BITS-1:0]   read_offset;
   logic [LEN_BITS-1:0]    read_length;
   logic [LEVEL_BITS-1:0]  new_priority;
   logic                   keep_priority;

   modport source (output valid, command, entry_index, file_size, mtime_seconds,
                   mtime_nanoseconds, now_seconds, read_offset, read_length,
                   new_priority, keep_priority, input ready);
   modport sink   (input valid, command, entry_index, file_size, mtime_seconds,
                   mtime_nanoseconds, now_seconds, read_offset, read_length,
                   new_priority, keep_priority, output ready);
endinterface

interface plfc_rsp_if;
   import plfc_pkg::*;
   logic                   valid;
   logic                   ready;
   logic                   read_hit;
   logic [LEN_BITS-1:0]    served_length;
   logic                   entry_cached;
   logic [CNT_BITS-1:0]    evicted_count;
   logic [TOTAL_BITS-1:0]  bytes_in_use;

   modport source (output valid, read_hit, served_length, entry_cached,
                   evicted_count, bytes_in_use, input ready);
   modport sink   (input valid, read_hit, served_length, entry_cached,
                   evicted_count, bytes_in_use, output ready);
endinterface

// ===== hw/rtl/plfc_ctrl.sv =====
// ----------------------------------------------------------------------------
// plfc_ctrl
// sequencer for lookup, list update and eviction walk
// ----------------------------------------------------------------------------
module plfc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  plfc_pkg::ctl_sts_type sts,
   output plfc_pkg::ctl_cmd_type cmd
);
   import plfc_pkg::*;

   typedef enum logic [13:0] {
      S_IDLE   = 14'b00000000000001,
      S_READ   = 14'b00000000000010,
      S_LOOK   = 14'b00000000000100,
      S_DROP   = 14'b00000000001000,
      S_WRITE  = 14'b00000000010000,
      S_REMOVE = 14'b00000000100000,
      S_APPEND = 14'b00000001000000,
      S_SETLV  = 14'b00000010000000,
      S_WSTART = 14'b00000100000000,
      S_WSCAN  = 14'b00001000000000,
      S_WREAD  = 14'b00010000000000,
      S_WDROP  = 14'b00100000000000,
      S_WPOST  = 14'b01000000000000,
      S_DONE   = 14'b10000000000000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = S_READ;
            end
         end
         S_READ: begin
            cmd.mem_read = 1'b1;
            state_in     = S_LOOK;
         end
         S_LOOK: begin
            cmd.set_result = 1'b1;
            case (sts.op)
               OP_INSTALL: state_in = sts.entry_valid ? S_DROP : S_WRITE;
               OP_REVAL: begin
                  if (!sts.entry_valid) state_in = S_DONE;
                  else if (sts.reval_ok) state_in = S_REMOVE;
                  else state_in = S_DROP;
               end
               OP_READ:   state_in = sts.read_ok ? S_REMOVE : S_DONE;
               OP_INVAL:  state_in = sts.entry_valid ? S_DROP : S_DONE;
               OP_SETPRI: state_in = sts.entry_valid ? S_REMOVE : S_SETLV;
               default:   state_in = S_DONE;
            endcase
         end
         S_DROP: begin
            cmd.drop = 1'b1;
            state_in = (sts.op == OP_INSTALL) ? S_WRITE : S_DONE;
         end
         S_WRITE: begin
            cmd.write_new = 1'b1;
            state_in      = S_APPEND;
         end
         S_REMOVE: begin
            cmd.remove      = 1'b1;
            cmd.write_stamp = (sts.op == OP_REVAL);
            cmd.write_level = (sts.op == OP_SETPRI);
            state_in        = S_APPEND;
         end
         S_APPEND: begin
            cmd.append = 1'b1;
            state_in   = (sts.op == OP_INSTALL) ? S_WSTART : S_DONE;
         end
         S_SETLV: begin
            cmd.write_level = 1'b1;
            state_in        = S_DONE;
         end
         S_WSTART: begin
            cmd.walk_clear = 1'b1;
            state_in       = sts.over_budget ? S_WSCAN : S_DONE;
         end
         S_WSCAN: begin
            if (sts.walk_nonempty) begin
               cmd.addr_head = 1'b1;
               state_in      = S_WREAD;
            end else if (sts.walk_last) begin
               state_in = S_DONE;
            end else begin
               cmd.walk_inc = 1'b1;
            end
         end
         S_WREAD: begin
            cmd.mem_read = 1'b1;
            state_in     = S_WDROP;
         end
         S_WDROP: begin
            cmd.drop    = 1'b1;
            cmd.cnt_inc = 1'b1;
            state_in    = S_WPOST;
         end
         S_WPOST: begin
            state_in = sts.under_budget ? S_DONE : S_WSCAN;
         end
         S_DONE: begin
            if (sts.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

// ===== hw/rtl/plfc_dp.sv =====
// ----------------------------------------------------------------------------
// plfc_dp
// entry metadata memories, lru links, byte total and result register
// ----------------------------------------------------------------------------
module plfc_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  plfc_pkg::cfg_type     cfg,
   input  plfc_pkg::ctl_cmd_type cmd,
   output plfc_pkg::ctl_sts_type sts,
   plfc_req_if.sink              req,
   plfc_rsp_if.source            rsp
);
   import plfc_pkg::*;

   // item registers
   logic [2:0]              op_ff;
   logic [ENTRY_BITS-1:0]   e_ff;
   logic [ENTRY_BITS-1:0]   item_e_ff;
   logic [SIZE_BITS-1:0]    fsize_ff;
   logic [TIME_BITS-1:0]    msec_ff;
   logic [NANO_BITS-1:0]    mnsec_ff;
   logic [TIME_BITS-1:0]    now_ff;
   logic [SIZE_BITS-1:0]    off_ff;
   logic [LEN_BITS-1:0]     len_ff;
   logic [LEVEL_BITS-1:0]   npri_ff;
   logic                    keep_ff;

   // memories and read data
   logic [SIZE_BITS-1:0]             bytes_mem [ENTRY_COUNT];
   logic [TIME_BITS+NANO_BITS-1:0]   mod_mem   [ENTRY_COUNT];
   logic [TIME_BITS-1:0]             stamp_mem [ENTRY_COUNT];
   logic [LEVEL_BITS-1:0]            level_mem [ENTRY_COUNT];
   logic [ENTRY_BITS-1:0]            next_mem  [ENTRY_COUNT];
   logic [ENTRY_BITS-1:0]            prev_mem  [ENTRY_COUNT];
   logic [SIZE_BITS-1:0]             bytes_q;
   logic [TIME_BITS+NANO_BITS-1:0]   mod_q;
   logic [TIME_BITS-1:0]             stamp_q;
   logic [LEVEL_BITS-1:0]            lv_q;
   logic [ENTRY_BITS-1:0]            next_q;
   logic [ENTRY_BITS-1:0]            prev_q;

   logic [ENTRY_COUNT-1:0]  valid_ff;
   logic [ENTRY_COUNT-1:0]  lvset_ff;
   logic [ENTRY_BITS-1:0]   head_ff [LEVEL_COUNT];
   logic [ENTRY_BITS-1:0]   tail_ff [LEVEL_COUNT];
   logic [LEVEL_COUNT-1:0]  nonempty_ff;
   logic [TOTAL_BITS-1:0]   total_ff, total_in;
   logic [LEVEL_BITS-1:0]   tlv_ff;
   logic [LEVEL_BITS-1:0]   wlv_ff;
   logic [CNT_BITS-1:0]     cnt_ff;
   logic                    hit_ff;
   logic [LEN_BITS-1:0]     served_ff;

   logic                    rsp_valid_ff;
   logic                    rsp_hit_ff;
   logic [LEN_BITS-1:0]     rsp_served_ff;
   logic                    rsp_cached_ff;
   logic [CNT_BITS-1:0]     rsp_cnt_ff;
   logic [TOTAL_BITS-1:0]   rsp_total_ff;

   logic                    is_head, is_tail, only_one;
   logic [PLEV_BITS-1:0]    levels, levels_m1;
   logic [LEVEL_BITS-1:0]   top_lv, new_lv;
   logic [TIME_BITS-1:0]    age;
   logic                    stale;
   logic [SIZE_BITS-1:0]    rest;
   logic [LEN_BITS-1:0]     served;
   logic [TOTAL_BITS:0]     sum;
   logic [TOTAL_BITS-1:0]   drop_bytes;

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         op_ff     <= req.command;
         item_e_ff <= req.entry_index;
         fsize_ff  <= req.file_size;
         msec_ff   <= req.mtime_seconds;
         mnsec_ff  <= req.mtime_nanoseconds;
         now_ff    <= req.now_seconds;
         off_ff    <= req.read_offset;
         len_ff    <= req.read_length;
         npri_ff   <= req.new_priority;
         keep_ff   <= req.keep_priority;
      end
      if (cmd.load_item) begin
         e_ff <= req.entry_index;
      end else if (cmd.addr_head) begin
         e_ff <= head_ff[wlv_ff];
      end
   end

   // list pointers of the entry being unlinked
   assign is_head  = (head_ff[lv_q] == e_ff);
   assign is_tail  = (tail_ff[lv_q] == e_ff);
   assign only_one = is_head && is_tail;
   logic unlink;
   assign unlink = cmd.remove || cmd.drop;

   always_ff @(posedge clock) begin
      if (cmd.write_new) begin
         bytes_mem[e_ff] <= fsize_ff;
         mod_mem[e_ff]   <= {msec_ff, mnsec_ff};
      end
      if (cmd.write_new || cmd.write_stamp) begin
         stamp_mem[e_ff] <= now_ff;
      end
      if (cmd.write_level) begin
         level_mem[e_ff] <= tlv_ff;
      end
      if (unlink && !only_one && !is_head) begin
         next_mem[prev_q] <= next_q;
      end else if (cmd.append && nonempty_ff[tlv_ff]) begin
         next_mem[tail_ff[tlv_ff]] <= e_ff;
      end
      if (unlink && !only_one && !is_tail) begin
         prev_mem[next_q] <= prev_q;
      end else if (cmd.append && nonempty_ff[tlv_ff]) begin
         prev_mem[e_ff] <= tail_ff[tlv_ff];
      end
      if (cmd.mem_read) begin
         bytes_q <= bytes_mem[e_ff];
         mod_q   <= mod_mem[e_ff];
         stamp_q <= stamp_mem[e_ff];
         lv_q    <= lvset_ff[e_ff] ? level_mem[e_ff] : '0;
         next_q  <= next_mem[e_ff];
         prev_q  <= prev_mem[e_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (unlink && !only_one) begin
         if (is_head) head_ff[lv_q] <= next_q;
         if (is_tail) tail_ff[lv_q] <= prev_q;
      end
      if (cmd.append) begin
         if (!nonempty_ff[tlv_ff]) head_ff[tlv_ff] <= e_ff;
         tail_ff[tlv_ff] <= e_ff;
      end
   end

   // byte total
   assign sum        = {1'b0, total_ff} + {{(TOTAL_BITS+1-SIZE_BITS){1'b0}}, fsize_ff};
   assign drop_bytes = {{(TOTAL_BITS-SIZE_BITS){1'b0}}, bytes_q};

   always_comb begin
      total_in = total_ff;
      if (cmd.drop) begin
         total_in = (drop_bytes > total_ff) ? '0 : total_ff - drop_bytes;
      end else if (cmd.write_new) begin
         total_in = sum[TOTAL_BITS] ? TOTAL_MAX : sum[TOTAL_BITS-1:0];
      end
   end

   // levels in use and clamped priority
   always_comb begin
      if (cfg.levels == '0) levels = PLEV_BITS'(1);
      else if (cfg.levels > PLEV_BITS'(LEVEL_COUNT)) levels = PLEV_BITS'(LEVEL_COUNT);
      else levels = cfg.levels;
   end
   assign levels_m1 = levels - PLEV_BITS'(1);
   assign top_lv    = levels_m1[LEVEL_BITS-1:0];
   assign new_lv    = keep_ff ? lv_q : ((npri_ff > top_lv) ? top_lv : npri_ff);

   // read checks
   assign age    = now_ff - stamp_q;
   assign stale  = !age[TIME_BITS-1] &&
                   (age >= {{(TIME_BITS-TIMEOUT_BITS){1'b0}}, cfg.timeout});
   assign rest   = bytes_q - off_ff;
   assign served = ({{(SIZE_BITS-LEN_BITS){1'b0}}, len_ff} < rest) ? len_ff
                                                                   : rest[LEN_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         lvset_ff    <= '0;
         nonempty_ff <= '0;
         total_ff    <= '0;
      end else begin
         total_ff <= total_in;
         if (cmd.drop) valid_ff[e_ff] <= 1'b0;
         if (cmd.write_new) valid_ff[e_ff] <= 1'b1;
         if (cmd.write_level) lvset_ff[e_ff] <= 1'b1;
         if (unlink && only_one) nonempty_ff[lv_q] <= 1'b0;
         if (cmd.append) nonempty_ff[tlv_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.set_result) begin
         tlv_ff <= (op_ff == OP_SETPRI) ? new_lv : lv_q;
      end
      if (cmd.walk_clear) begin
         wlv_ff <= '0;
      end else if (cmd.walk_inc) begin
         wlv_ff <= wlv_ff + LEVEL_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         hit_ff    <= 1'b0;
         served_ff <= '0;
      end else if (cmd.load_item) begin
         cnt_ff    <= '0;
         hit_ff    <= 1'b0;
         served_ff <= '0;
      end else begin
         if (cmd.cnt_inc) cnt_ff <= cnt_ff + CNT_BITS'(1);
         if (cmd.set_result && (op_ff == OP_READ) && sts.read_ok) begin
            hit_ff    <= 1'b1;
            served_ff <= served;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.load_rsp) begin
         rsp_hit_ff    <= hit_ff;
         rsp_served_ff <= served_ff;
         rsp_cached_ff <= valid_ff[item_e_ff];
         rsp_cnt_ff    <= cnt_ff;
         rsp_total_ff  <= total_ff;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.read_hit      = rsp_hit_ff;
   assign rsp.served_length = rsp_served_ff;
   assign rsp.entry_cached  = rsp_cached_ff;
   assign rsp.evicted_count = rsp_cnt_ff;
   assign rsp.bytes_in_use  = rsp_total_ff;

   assign sts.op            = op_ff;
   assign sts.entry_valid   = valid_ff[e_ff];
   assign sts.reval_ok      = (fsize_ff <= {{(SIZE_BITS-MAXFILE_BITS){1'b0}}, cfg.maxfile}) &&
                              (mod_q == {msec_ff, mnsec_ff});
   assign sts.read_ok       = valid_ff[e_ff] && (off_ff < bytes_q) && !stale;
   assign sts.over_budget   = total_ff > {{(TOTAL_BITS-BUDGET_BITS){1'b0}}, cfg.budget};
   assign sts.under_budget  = total_ff < {{(TOTAL_BITS-BUDGET_BITS){1'b0}}, cfg.budget};
   assign sts.walk_nonempty = nonempty_ff[wlv_ff];
   assign sts.walk_last     = ({1'b0, wlv_ff} == levels_m1);
   assign sts.rsp_free      = !rsp_valid_ff || rsp.ready;

   a_append_marks: assert property (@(posedge clock) disable iff (reset)
      cmd.append |=> nonempty_ff[$past(tlv_ff)])
      else $error("list empty after append");
   a_walk_count: assert property (@(posedge clock) disable iff (reset)
      cmd.cnt_inc |=> cnt_ff == $past(cnt_ff) + CNT_BITS'(1))
      else $error("eviction count not advanced");
   a_install_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.write_new |=> valid_ff[$past(e_ff)])
      else $error("installed entry not valid");

endmodule

// ===== hw/rtl/priority_lru_file_cache_policy_unit.sv =====
// ----------------------------------------------------------------------------
// priority_lru_file_cache_policy_unit
// whole-file cache metadata and priority lru replacement engine
// ----------------------------------------------------------------------------
// One item is in flight at a time. An item that changes nothing (uncached
// entry, read miss, unknown command) passes the read, lookup and done states;
// dropping a cached entry adds the drop state, a bump or successful
// revalidation remove and append, and an install write, append and walk start
// (and drop when it replaces cached content) plus the eviction walk of scan,
// read, drop and budget check per evicted entry and a scan step per empty
// level. The next request is taken in the cycle after the response is loaded.
// The pace is set by the single read port of the entry memories and the
// one-step list unlink and append sequencer.
// ----------------------------------------------------------------------------
module priority_lru_file_cache_policy_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   plfc_req_if.sink                             req,
   plfc_rsp_if.source                           rsp,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [plfc_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [plfc_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [plfc_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                 csr_pready
);
   import plfc_pkg::*;

   cfg_type       cfg_ff;
   ctl_cmd_type   cmd;
   ctl_sts_type   sts;
   reg_index_type csr_idx;
   logic          csr_wr;
   logic          ctrl_ready;

   assign csr_pready = 1'b1;
   assign csr_idx    = reg_index_type'(csr_paddr[CSR_ADDR_BITS-1:3]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign req.ready  = ctrl_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.budget  <= BUDGET_RESET;
         cfg_ff.timeout <= TIMEOUT_RESET;
         cfg_ff.maxfile <= MAXFILE_RESET;
         cfg_ff.levels  <= PLEV_RESET;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_BUDGET:  cfg_ff.budget  <= csr_pwdata[BUDGET_BITS-1:0];
            REG_TIMEOUT: cfg_ff.timeout <= csr_pwdata[TIMEOUT_BITS-1:0];
            REG_MAXFILE: cfg_ff.maxfile <= csr_pwdata[MAXFILE_BITS-1:0];
            REG_LEVELS:  cfg_ff.levels  <= csr_pwdata[PLEV_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_BUDGET:  csr_prdata = CSR_DATA_BITS'(cfg_ff.budget);
         REG_TIMEOUT: csr_prdata = CSR_DATA_BITS'(cfg_ff.timeout);
         REG_MAXFILE: csr_prdata = CSR_DATA_BITS'(cfg_ff.maxfile);
         REG_LEVELS:  csr_prdata = CSR_DATA_BITS'(cfg_ff.levels);
         default:     csr_prdata = '0;
      endcase
   end

   plfc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (ctrl_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   plfc_dp u_dp (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg_ff),
      .cmd   (cmd),
      .sts   (sts),
      .req   (req),
      .rsp   (rsp)
   );

endmodule

// ===== tb/priority_lru_file_cache_policy_unit_test.sv =====
// ----------------------------------------------------------------------------
// priority_lru_file_cache_policy_unit_test
// self-checking regression of the file cache policy unit
// ----------------------------------------------------------------------------
// A short directed table covers the reset state, the field extremes, every
// command and the corner cases of freshness, clamping and the eviction walk.
// Random traffic over several register settings follows.
// Every response is checked field by field against an in-bench model of the
// lru lists, the byte total and the budget walk. Both channel sides insert
// random idle cycles, the response side stalls once for a long stretch and
// the request side pauses once until the unit is drained.
// ----------------------------------------------------------------------------
module priority_lru_file_cache_policy_unit_test;
   import plfc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int          CYCLE_LIMIT    = 4000000;
   localparam int          LONG_STALL     = 400;
   localparam int          RANDOM_PHASES  = 8;
   localparam int          PHASE_ITEMS    = 125;
   localparam bit [2:0]    OP_SPARE_FIVE  = 3'd5;
   localparam bit [2:0]    OP_SPARE_SEVEN = 3'd7;

   typedef struct {
      bit [2:0]            command;
      bit [ENTRY_BITS-1:0] entry_index;
      bit [SIZE_BITS-1:0]  file_size;
      bit [TIME_BITS-1:0]  mtime_seconds;
      bit [NANO_BITS-1:0]  mtime_nanoseconds;
      bit [TIME_BITS-1:0]  now_seconds;
      bit [SIZE_BITS-1:0]  read_offset;
      bit [LEN_BITS-1:0]   read_length;
      bit [LEVEL_BITS-1:0] new_priority;
      bit                  keep_priority;
   } cache_op_t;

   typedef struct {
      bit                  read_hit;
      bit [LEN_BITS-1:0]   served_length;
      bit                  entry_cached;
      bit [CNT_BITS-1:0]   evicted_count;
      bit [TOTAL_BITS-1:0] bytes_in_use;
   } cache_status_t;

   typedef struct {
      cache_op_t     op;
      bit            typed;
      cache_status_t status;
   } table_row_t;

   logic clock;
   logic reset;
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   plfc_req_if req_if();
   plfc_rsp_if rsp_if();

   priority_lru_file_cache_policy_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_if),
      .rsp         (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // shadow of the unit
   bit [BUDGET_BITS-1:0]  m_budget;
   bit [TIMEOUT_BITS-1:0] m_timeout;
   bit [MAXFILE_BITS-1:0] m_maxfile;
   bit [PLEV_BITS-1:0]    m_levels;
   bit                    m_valid [ENTRY_COUNT];
   bit [SIZE_BITS-1:0]    m_bytes [ENTRY_COUNT];
   bit [LEVEL_BITS-1:0]   m_level [ENTRY_COUNT];
   bit [TIME_BITS-1:0]    m_msec  [ENTRY_COUNT];
   bit [NANO_BITS-1:0]    m_mnsec [ENTRY_COUNT];
   bit [TIME_BITS-1:0]    m_stamp [ENTRY_COUNT];
   bit [ENTRY_BITS-1:0]   m_next  [ENTRY_COUNT];
   bit [ENTRY_BITS-1:0]   m_prev  [ENTRY_COUNT];
   bit [ENTRY_BITS-1:0]   m_head  [LEVEL_COUNT];
   bit [ENTRY_BITS-1:0]   m_tail  [LEVEL_COUNT];
   bit                    m_busy  [LEVEL_COUNT];
   bit [TOTAL_BITS-1:0]   m_total;

   cache_status_t status_q[$];
   table_row_t    rows[$];
   int  errors;
   int  sent;
   int  checked;
   int  hits;
   int  evictions;
   int  cycles;
   bit  hold_rsp;
   bit [TIME_BITS-1:0] base_time;

   function automatic int levels_used();
      if (m_levels == 0) return 1;
      if (m_levels > LEVEL_COUNT) return LEVEL_COUNT;
      return m_levels;
   endfunction

   function automatic void unlink(int e);
      int lv;
      bit at_head;
      bit at_tail;
      lv = m_level[e];
      at_head = m_head[lv] == e;
      at_tail = m_tail[lv] == e;
      if (at_head && at_tail) begin
         m_busy[lv] = 0;
         return;
      end
      if (at_head) m_head[lv] = m_next[e];
      else m_next[m_prev[e]] = m_next[e];
      if (at_tail) m_tail[lv] = m_prev[e];
      else m_prev[m_next[e]] = m_prev[e];
   endfunction

   function automatic void push_tail(int e);
      int lv;
      lv = m_level[e];
      if (!m_busy[lv]) begin
         m_head[lv] = e;
         m_busy[lv] = 1;
      end else begin
         m_next[m_tail[lv]] = e;
         m_prev[e] = m_tail[lv];
      end
      m_tail[lv] = e;
   endfunction

   function automatic void drop(int e);
      if (!m_valid[e]) return;
      unlink(e);
      m_total = ({8'b0, m_bytes[e]} > m_total) ? '0 : m_total - m_bytes[e];
      m_bytes[e] = '0;
      m_valid[e] = 0;
   endfunction

   function automatic void bump(int e);
      if (!m_valid[e]) return;
      unlink(e);
      push_tail(e);
   endfunction

   function automatic int evict_to_budget();
      int n;
      n = 0;
      if (m_total <= m_budget) return 0;
      for (int lv = 0; lv < levels_used(); lv++) begin
         while (m_busy[lv]) begin
            drop(m_head[lv]);
            n++;
            if (m_total < m_budget) return n;
         end
      end
      return n;
   endfunction

   function automatic cache_status_t cache_predict(cache_op_t x);
      cache_status_t r;
      int e;
      bit [TIME_BITS-1:0] age;
      bit [SIZE_BITS-1:0] rest;
      bit [LEVEL_BITS-1:0] lv;
      int top;
      r = '{default: 0};
      e = x.entry_index;
      case (x.command)
         OP_INSTALL: begin
            drop(e);
            m_bytes[e] = x.file_size;
            m_msec[e]  = x.mtime_seconds;
            m_mnsec[e] = x.mtime_nanoseconds;
            m_stamp[e] = x.now_seconds;
            m_valid[e] = 1;
            m_total = ({8'b0, x.file_size} > TOTAL_MAX - m_total) ? TOTAL_MAX
                      : m_total + x.file_size;
            push_tail(e);
            r.evicted_count = evict_to_budget();
         end
         OP_REVAL: begin
            if (m_valid[e]) begin
               if (x.file_size <= m_maxfile && m_msec[e] == x.mtime_seconds &&
                   m_mnsec[e] == x.mtime_nanoseconds) begin
                  m_stamp[e] = x.now_seconds;
                  bump(e);
               end else drop(e);
            end
         end
         OP_READ: begin
            if (m_valid[e] && x.read_offset < m_bytes[e]) begin
               age = x.now_seconds - m_stamp[e];
               if (!(age < 32'h8000_0000 && age >= m_timeout)) begin
                  rest = m_bytes[e] - x.read_offset;
                  r.read_hit = 1;
                  r.served_length = ({8'b0, x.read_length} < rest) ? x.read_length
                                    : rest[LEN_BITS-1:0];
                  bump(e);
               end
            end
         end
         OP_INVAL: drop(e);
         OP_SETPRI: begin
            lv = m_level[e];
            if (!x.keep_priority) begin
               top = levels_used() - 1;
               lv = (x.new_priority > top) ? LEVEL_BITS'(top) : x.new_priority;
            end
            if (m_valid[e]) begin
               unlink(e);
               m_level[e] = lv;
               push_tail(e);
            end else m_level[e] = lv;
         end
         default: ;
      endcase
      r.entry_cached = m_valid[e];
      r.bytes_in_use = m_total;
      return r;
   endfunction

   function automatic cache_op_t mk(bit [2:0] c, bit [7:0] e, bit [39:0] sz,
                                    bit [31:0] ms, bit [29:0] mn, bit [31:0] nw,
                                    bit [39:0] off, bit [31:0] len,
                                    bit [2:0] np, bit kp);
      cache_op_t x;
      x.command = c; x.entry_index = e; x.file_size = sz;
      x.mtime_seconds = ms; x.mtime_nanoseconds = mn; x.now_seconds = nw;
      x.read_offset = off; x.read_length = len; x.new_priority = np;
      x.keep_priority = kp;
      return x;
   endfunction

   function automatic cache_status_t st(bit h, bit [31:0] s, bit c, bit [8:0] ev,
                                        bit [47:0] t);
      cache_status_t r;
      r.read_hit = h; r.served_length = s; r.entry_cached = c;
      r.evicted_count = ev; r.bytes_in_use = t;
      return r;
   endfunction

   function automatic bit [39:0] wide40();
      return {$urandom, $urandom};
   endfunction

   function automatic cache_op_t random_op();
      cache_op_t x;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 30) x.command = OP_INSTALL;
      else if (pick < 45) x.command = OP_REVAL;
      else if (pick < 75) x.command = OP_READ;
      else if (pick < 83) x.command = OP_INVAL;
      else if (pick < 95) x.command = OP_SETPRI;
      else x.command = $urandom_range(OP_SPARE_FIVE, OP_SPARE_SEVEN);
      x.entry_index = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 15);
      x.file_size = ($urandom_range(0, 19) == 0) ? wide40() : $urandom_range(0, 3000);
      x.mtime_seconds = ($urandom_range(0, 9) == 0) ? $urandom : 1000 + $urandom_range(0, 1);
      x.mtime_nanoseconds = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 999999999)
                            : $urandom_range(0, 1) * 5;
      if ($urandom_range(0, 3) == 0) base_time = base_time + $urandom_range(1, 8);
      x.now_seconds = ($urandom_range(0, 19) == 0) ? $urandom
                      : base_time + $urandom_range(0, 3) - 1;
      x.read_offset = ($urandom_range(0, 19) == 0) ? wide40() : $urandom_range(0, 3500);
      x.read_length = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 2000);
      x.new_priority = $urandom;
      x.keep_priority = $urandom;
      return x;
   endfunction

   task automatic csr_write(reg_index_type r, bit [CSR_DATA_BITS-1:0] value);
      @(negedge clock);
      csr_psel    <= 1;
      csr_penable <= 0;
      csr_pwrite  <= 1;
      csr_paddr   <= {r, 3'b000};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 0;
      csr_penable <= 0;
      csr_pwrite  <= 0;
   endtask

   task automatic configure(bit [35:0] b, bit [5:0] t, bit [19:0] m, bit [3:0] l);
      csr_write(REG_BUDGET, b);
      csr_write(REG_TIMEOUT, t);
      csr_write(REG_MAXFILE, m);
      csr_write(REG_LEVELS, l);
      m_budget = b; m_timeout = t; m_maxfile = m; m_levels = l;
   endtask

   task automatic drain();
      while (status_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic send(cache_op_t x, bit typed, cache_status_t typed_status);
      int gap;
      cache_status_t p;
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
      @(negedge clock);
      if (gap > 0) begin
         req_if.valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_if.command           <= x.command;
      req_if.entry_index       <= x.entry_index;
      req_if.file_size         <= x.file_size;
      req_if.mtime_seconds     <= x.mtime_seconds;
      req_if.mtime_nanoseconds <= x.mtime_nanoseconds;
      req_if.now_seconds       <= x.now_seconds;
      req_if.read_offset       <= x.read_offset;
      req_if.read_length       <= x.read_length;
      req_if.new_priority      <= x.new_priority;
      req_if.keep_priority     <= x.keep_priority;
      req_if.valid             <= 1;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      p = cache_predict(x);
      status_q.push_back(typed ? typed_status : p);
      sent++;
   endtask

   task automatic idle_request();
      @(negedge clock);
      req_if.valid <= 0;
   endtask

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses pending", cycles,
                  status_q.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   // response side
   initial begin
      cache_status_t exp_s;
      int w;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         w = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
         if (hold_rsp) begin
            w = LONG_STALL;
            hold_rsp = 0;
         end
         if (w > 0) begin
            rsp_if.ready <= 0;
            repeat (w) @(negedge clock);
         end
         rsp_if.ready <= 1;
         @(posedge clock);
         while (!rsp_if.valid) @(posedge clock);
         checked++;
         if (status_q.size() == 0) begin
            errors++;
            $error("response transfer with nothing expected");
         end else begin
            exp_s = status_q.pop_front();
            if (rsp_if.read_hit !== exp_s.read_hit) begin
               errors++;
               $error("read_hit expected %0d actual %0d", exp_s.read_hit, rsp_if.read_hit);
            end
            if (rsp_if.served_length !== exp_s.served_length) begin
               errors++;
               $error("served_length expected %0d actual %0d", exp_s.served_length,
                      rsp_if.served_length);
            end
            if (rsp_if.entry_cached !== exp_s.entry_cached) begin
               errors++;
               $error("entry_cached expected %0d actual %0d", exp_s.entry_cached,
                      rsp_if.entry_cached);
            end
            if (rsp_if.evicted_count !== exp_s.evicted_count) begin
               errors++;
               $error("evicted_count expected %0d actual %0d", exp_s.evicted_count,
                      rsp_if.evicted_count);
            end
            if (rsp_if.bytes_in_use !== exp_s.bytes_in_use) begin
               errors++;
               $error("bytes_in_use expected %0d actual %0d", exp_s.bytes_in_use,
                      rsp_if.bytes_in_use);
            end
            if (exp_s.read_hit) hits++;
            evictions += exp_s.evicted_count;
         end
         @(negedge clock);
      end
   end

   initial begin
      bit [35:0] cb [RANDOM_PHASES];
      bit [5:0]  ct [RANDOM_PHASES];
      bit [19:0] cm [RANDOM_PHASES];
      bit [3:0]  cl [RANDOM_PHASES];
      cache_status_t none;
      errors = 0; sent = 0; checked = 0; hits = 0; evictions = 0; cycles = 0;
      hold_rsp = 0;
      base_time = 32'd5000;
      none = '{default: 0};
      reset = 1;
      csr_psel = 0; csr_penable = 0; csr_pwrite = 0; csr_paddr = '0; csr_pwdata = '0;
      req_if.valid = 0; req_if.command = '0; req_if.entry_index = '0;
      req_if.file_size = '0; req_if.mtime_seconds = '0; req_if.mtime_nanoseconds = '0;
      req_if.now_seconds = '0; req_if.read_offset = '0; req_if.read_length = '0;
      req_if.new_priority = '0; req_if.keep_priority = 0;
      rsp_if.ready = 0;
      for (int i = 0; i < ENTRY_COUNT; i++) begin
         m_valid[i] = 0; m_bytes[i] = '0; m_level[i] = '0; m_msec[i] = '0;
         m_mnsec[i] = '0; m_stamp[i] = '0; m_next[i] = '0; m_prev[i] = '0;
      end
      for (int i = 0; i < LEVEL_COUNT; i++) begin
         m_head[i] = '0; m_tail[i] = '0; m_busy[i] = 0;
      end
      m_total = '0;
      m_budget = BUDGET_RESET; m_timeout = TIMEOUT_RESET;
      m_maxfile = MAXFILE_RESET; m_levels = PLEV_RESET;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed table, reset register values
      rows.push_back('{mk(OP_READ, 0, 0, 0, 0, 0, 0, 10, 0, 0), 1, st(0, 0, 0, 0, 0)});
      rows.push_back('{mk(OP_INSTALL, 1, 100, 7, 3, 50, 0, 0, 0, 0), 1,
                       st(0, 0, 1, 0, 100)});
      rows.push_back('{mk(OP_READ, 1, 0, 0, 0, 50, 0, 50, 0, 0), 1, st(1, 50, 1, 0, 100)});
      rows.push_back('{mk(OP_READ, 1, 0, 0, 0, 50, 99, 32'hFFFF_FFFF, 0, 0), 1,
                       st(1, 1, 1, 0, 100)});
      rows.push_back('{mk(OP_READ, 1, 0, 0, 0, 50, 100, 5, 0, 0), 1, st(0, 0, 1, 0, 100)});
      // stale at age equal to the timeout, fresh at negative age
      rows.push_back('{mk(OP_READ, 1, 0, 0, 0, 51, 0, 5, 0, 0), 1, st(0, 0, 1, 0, 100)});
      rows.push_back('{mk(OP_READ, 1, 0, 0, 0, 49, 0, 10, 0, 0), 1, st(1, 10, 1, 0, 100)});
      rows.push_back('{mk(OP_REVAL, 1, 100, 7, 3, 60, 0, 0, 0, 0), 1,
                       st(0, 0, 1, 0, 100)});
      rows.push_back('{mk(OP_REVAL, 1, 100, 7, 4, 60, 0, 0, 0, 0), 1, st(0, 0, 0, 0, 0)});
      rows.push_back('{mk(OP_INSTALL, 2, 40'hFF_FFFF_FFFF, 0, 0, 60, 0, 0, 0, 0), 1,
                       st(0, 0, 0, 1, 0)});
      rows.push_back('{mk(OP_SETPRI, 3, 0, 0, 0, 0, 0, 0, 7, 0), 1, st(0, 0, 0, 0, 0)});
      rows.push_back('{mk(OP_INSTALL, 3, 200, 1, 1, 70, 0, 0, 0, 0), 1,
                       st(0, 0, 1, 0, 200)});
      rows.push_back('{mk(OP_INSTALL, 4, 300, 2, 2, 70, 0, 0, 0, 0), 1,
                       st(0, 0, 1, 0, 500)});
      rows.push_back('{mk(OP_SETPRI, 3, 0, 0, 0, 0, 0, 0, 5, 1), 0, none});
      rows.push_back('{mk(OP_SPARE_FIVE, 3, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                       st(0, 0, 1, 0, 500)});
      rows.push_back('{mk(OP_SPARE_SEVEN, 4, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                       st(0, 0, 1, 0, 500)});
      rows.push_back('{mk(OP_INVAL, 3, 0, 0, 0, 0, 0, 0, 0, 0), 1, st(0, 0, 0, 0, 300)});
      rows.push_back('{mk(OP_REVAL, 4, 65537, 2, 2, 80, 0, 0, 0, 0), 1,
                       st(0, 0, 0, 0, 0)});
      rows.push_back('{mk(OP_INSTALL, 255, 65536, 32'hFFFF_FFFF, 999999999,
                          32'hFFFF_FFFF, 0, 0, 0, 0), 0, none});
      rows.push_back('{mk(OP_READ, 255, 0, 0, 0, 0, 0, 0, 0, 0), 0, none});
      rows.push_back('{mk(OP_READ, 255, 0, 0, 0, 32'hFFFF_FFFF, 40'hFF_FFFF_FFFF, 0, 0, 0),
                       0, none});
      rows.push_back('{mk(OP_REVAL, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                       st(0, 0, 0, 0, 65536)});
      foreach (rows[i]) send(rows[i].op, rows[i].typed, rows[i].status);
      idle_request();
      drain();

      cb[0] = 20000;          ct[0] = 5;  cm[0] = 2500;     cl[0] = 3;
      cb[1] = 0;              ct[1] = 60; cm[1] = 1024000;  cl[1] = 8;
      cb[2] = 36'hF_FFFF_FFFF; ct[2] = 0; cm[2] = 0;        cl[2] = 0;
      cb[3] = 6000;           ct[3] = 63; cm[3] = 20'hFFFFF; cl[3] = 15;
      cb[4] = 36'd34359738368; ct[4] = 1; cm[4] = 1000;     cl[4] = 1;
      cb[5] = 4000;           ct[5] = 10; cm[5] = 2000;     cl[5] = 4;
      cb[6] = 9000;           ct[6] = 30; cm[6] = 3000;     cl[6] = 2;
      cb[7] = 12000;          ct[7] = 2;  cm[7] = 1500;     cl[7] = 8;

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         configure(cb[ph], ct[ph], cm[ph], cl[ph]);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (ph == 2 && n == PHASE_ITEMS / 2) hold_rsp = 1;
            if (ph == 4 && n == PHASE_ITEMS / 2) begin
               idle_request();
               while (status_q.size() != 0) @(posedge clock);
            end
            send(random_op(), 0, none);
         end
         idle_request();
         drain();
      end

      drain();
      if (status_q.size() != 0) begin
         errors++;
         $error("%0d expected responses never arrived", status_q.size());
      end
      $display("%0d requests over %0d register settings, %0d responses checked",
               sent, RANDOM_PHASES + 1, checked);
      $display("%0d read hits, %0d budget evictions", hits, evictions);
      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
